>>> hw/rtl/primality_tester_assert.svh
// Assertion macros for the primality tester.
`ifndef PRIMALITY_TESTER_ASSERT_SVH
`define PRIMALITY_TESTER_ASSERT_SVH
`ifndef SYNTHESIS
`define PT_ASSERT(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error("assertion failed");
`define PT_ASSERT_NR(label, clk_s, prop) \
  label: assert property (@(posedge clk_s) (prop)) else $error("assertion failed");
`else
`define PT_ASSERT(label, clk_s, rst_s, prop)
`define PT_ASSERT_NR(label, clk_s, prop)
`endif
`endif

>>> hw/rtl/pt_pkg.sv
// Shared types and constants for the primality tester.
`default_nettype none
package pt_pkg;
  localparam int NB = 63;
  localparam logic [2:0] METH_TRIAL = 3'd0;
  localparam logic [2:0] METH_MR    = 3'd1;
  localparam logic [2:0] METH_FERM  = 3'd2;
  localparam logic [2:0] METH_MR5   = 3'd3;
  localparam logic [2:0] METH_MR10  = 3'd4;
  localparam logic [0:0] REG_METHOD = 1'b0;
  localparam logic [0:0] REG_ROUNDS = 1'b1;
  localparam logic [63:0] LIM_A = 64'd1373653;
  localparam logic [63:0] LIM_B = 64'd25326001;

  // Small prime bases for exact mode, indexed 0..11.
  function automatic logic [5:0] prime_at(input logic [3:0] i);
    case (i)
      4'd0: prime_at = 6'd2;   4'd1: prime_at = 6'd3;   4'd2: prime_at = 6'd5;
      4'd3: prime_at = 6'd7;   4'd4: prime_at = 6'd11;  4'd5: prime_at = 6'd13;
      4'd6: prime_at = 6'd17;  4'd7: prime_at = 6'd19;  4'd8: prime_at = 6'd23;
      4'd9: prime_at = 6'd29;  4'd10: prime_at = 6'd31; 4'd11: prime_at = 6'd37;
      default: prime_at = 6'd2;
    endcase
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_SPLIT, ST_BASE, ST_POW, ST_POW_WAIT, ST_SQ, ST_SQ_WAIT,
    ST_NEXT, ST_DONE
  } state_t;

  // Exponent sequencing phase in the datapath.
  typedef enum logic [1:0] {P_IDLE, P_MUL, P_SQR} ph_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture candidate
    logic split_step; // shift d right one place
    logic set_base;   // load base and start pow(base, exp)
    logic fermat;     // exponent is n-1 instead of d
    logic sq_start;   // x = x*x mod n
    logic [6:0] base;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic busy;
    logic d_even;
    logic x_one;
    logic x_nm1;
    logic n_small;   // n < 2
    logic n_even;
    logic n_eq2or3;
    logic lt_a;
    logic lt_b;
    logic [NB-1:0] n;
  } stat_t;
endpackage
`default_nettype wire

>>> hw/rtl/pt_datapath.sv
// Modular exponentiation datapath with a bit-serial mod multiplier.
`default_nettype none
module pt_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [62:0]    cand,
  input  wire pt_pkg::cmd_t   cmd,
  output pt_pkg::stat_t       stat
);
  logic [62:0] n, d, e, x, bse, ma, mb, mr;
  logic [63:0] sum_ra, sum_aa;
  logic        mbusy, pbusy, psq_only, pmul_x;
  pt_pkg::ph_t ph;

  // Add-mod helpers
  assign sum_ra = {1'b0, mr} + {1'b0, ma};
  assign sum_aa = {1'b0, ma} + {1'b0, ma};

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0; pbusy <= 1'b0; ph <= pt_pkg::P_IDLE;
    end else begin
      if (cmd.load) begin
        n <= cand; d <= cand - 63'd1;
      end
      if (cmd.split_step) d <= d >> 1;
      // Start exponent: x = 1 mod n, base is always below n here
      if (cmd.set_base) begin
        x <= (n == 63'd1) ? 63'd0 : 63'd1;
        bse <= {56'd0, cmd.base};
        e <= cmd.fermat ? n - 63'd1 : d;
        pbusy <= 1'b1; ph <= pt_pkg::P_IDLE; psq_only <= 1'b0;
      end
      if (cmd.sq_start) begin
        ma <= x; mb <= x; mr <= '0; mbusy <= 1'b1;
        pbusy <= 1'b1; psq_only <= 1'b1; ph <= pt_pkg::P_SQR; pmul_x <= 1'b1;
      end
      // Serial multiply: one bit of mb per cycle
      if (mbusy) begin
        if (mb[0]) mr <= (sum_ra >= {1'b0, n}) ? 63'(sum_ra - {1'b0, n}) : sum_ra[62:0];
        ma <= (sum_aa >= {1'b0, n}) ? 63'(sum_aa - {1'b0, n}) : sum_aa[62:0];
        mb <= mb >> 1;
        if (mb == 63'd0) begin
          mbusy <= 1'b0;
          if (pmul_x) x <= mr; else bse <= mr;
        end
      end else if (pbusy && !cmd.set_base && !cmd.sq_start) begin
        // Exponent sequencing
        case (ph)
          pt_pkg::P_IDLE: begin
            if (psq_only) begin
              pbusy <= 1'b0;
            end else if (e == 63'd0) begin
              pbusy <= 1'b0;
            end else if (e[0]) begin
              ma <= x; mb <= bse; mr <= '0; mbusy <= 1'b1; pmul_x <= 1'b1;
              ph <= pt_pkg::P_MUL;
            end else begin
              ma <= bse; mb <= bse; mr <= '0; mbusy <= 1'b1; pmul_x <= 1'b0;
              ph <= pt_pkg::P_SQR;
            end
          end
          pt_pkg::P_MUL: begin
            ma <= bse; mb <= bse; mr <= '0; mbusy <= 1'b1; pmul_x <= 1'b0;
            ph <= pt_pkg::P_SQR;
          end
          pt_pkg::P_SQR: begin
            if (!psq_only) e <= e >> 1;
            ph <= pt_pkg::P_IDLE;
          end
          default: ph <= pt_pkg::P_IDLE;
        endcase
      end
    end
  end

  // Status back to the controller
  always_comb begin
    stat.busy     = mbusy | pbusy;
    stat.d_even   = (d[0] == 1'b0) && (d != 63'd0);
    stat.x_one    = (x == 63'd1);
    stat.x_nm1    = (x == n - 63'd1);
    stat.n_small  = (n < 63'd2);
    stat.n_even   = ~n[0];
    stat.n_eq2or3 = (n == 63'd2) || (n == 63'd3);
    stat.lt_a     = ({1'b0, n} < pt_pkg::LIM_A);
    stat.lt_b     = ({1'b0, n} < pt_pkg::LIM_B);
    stat.n        = n;
  end
endmodule
`default_nettype wire

>>> hw/rtl/pt_control.sv
// Test sequencer for the primality tester.
`default_nettype none
module pt_control (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [2:0]    method,
  input  wire logic [5:0]    rounds_cfg,
  input  wire logic          out_free,
  input  wire pt_pkg::stat_t stat,
  output pt_pkg::cmd_t       cmd,
  output logic               done,
  output logic               verdict,
  output logic               idle
);
  pt_pkg::state_t st, st_next;
  logic [5:0] r, rmax, s, j;
  logic       pass, exact, ferm;
  logic [6:0] base_c;
  logic [63:0] nm2;

  assign nm2 = {1'b0, stat.n} - 64'd2;

  // Base schedule
  always_comb begin
    if (exact) base_c = {1'b0, pt_pkg::prime_at(r[3:0])};
    else if (ferm) base_c = {1'b0, r} + 7'd2;
    else if (stat.lt_a) base_c = (r == 6'd0) ? 7'd2 : 7'd3;
    else if (stat.lt_b) base_c = (r == 6'd0) ? 7'd2 : (r == 6'd1) ? 7'd3 : 7'd5;
    else base_c = {1'b0, r} + 7'd2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= pt_pkg::ST_IDLE;
    end else begin
      st <= st_next;
      case (st)
        pt_pkg::ST_IDLE: if (start) begin
          exact <= (method == pt_pkg::METH_TRIAL);
          ferm  <= (method == pt_pkg::METH_FERM);
          case (method)
            pt_pkg::METH_TRIAL: rmax <= 6'd12;
            pt_pkg::METH_MR5:   rmax <= 6'd5;
            pt_pkg::METH_MR10:  rmax <= 6'd10;
            pt_pkg::METH_FERM:  rmax <= (rounds_cfg > 6'd2) ? rounds_cfg - 6'd2 : 6'd0;
            default:            rmax <= rounds_cfg;
          endcase
          pass <= (method <= pt_pkg::METH_MR10);
          r <= '0; s <= '0;
        end
        pt_pkg::ST_CHECK: begin
          if (stat.n_small) pass <= 1'b0;
          else if (stat.n_eq2or3) pass <= pass;
          else if (stat.n_even) pass <= 1'b0;
        end
        pt_pkg::ST_SPLIT: if (stat.d_even) s <= s + 6'd1;
        pt_pkg::ST_POW_WAIT: if (!stat.busy) j <= 6'd1;
        pt_pkg::ST_SQ_WAIT: if (!stat.busy) j <= j + 6'd1;
        pt_pkg::ST_NEXT: r <= r + 6'd1;
        default: ;
      endcase
      if (st == pt_pkg::ST_POW_WAIT && !stat.busy) begin
        if (ferm) begin
          if (!stat.x_one) pass <= 1'b0;
        end else if (!(stat.x_one || stat.x_nm1) && s <= 6'd1) pass <= 1'b0;
      end
      if (st == pt_pkg::ST_SQ_WAIT && !stat.busy && !stat.x_nm1 && j + 6'd1 >= s)
        pass <= 1'b0;
    end
  end

  // Next state
  always_comb begin
    st_next = st;
    case (st)
      pt_pkg::ST_IDLE:  if (start) st_next = pt_pkg::ST_CHECK;
      pt_pkg::ST_CHECK: begin
        if (!pass || stat.n_small || stat.n_eq2or3 || stat.n_even) st_next = pt_pkg::ST_DONE;
        else st_next = pt_pkg::ST_SPLIT;
      end
      pt_pkg::ST_SPLIT: if (!stat.d_even) st_next = pt_pkg::ST_BASE;
      pt_pkg::ST_BASE: begin
        if (r >= rmax) st_next = pt_pkg::ST_DONE;
        else if (exact && {57'd0, base_c} == {1'b0, stat.n}) st_next = pt_pkg::ST_DONE;
        else if (!exact && ({57'd0, base_c} >= nm2)) st_next = pt_pkg::ST_NEXT;
        else st_next = pt_pkg::ST_POW;
      end
      pt_pkg::ST_POW: st_next = pt_pkg::ST_POW_WAIT;
      pt_pkg::ST_POW_WAIT: if (!stat.busy) begin
        if (ferm) st_next = stat.x_one ? pt_pkg::ST_NEXT : pt_pkg::ST_DONE;
        else if (stat.x_one || stat.x_nm1) st_next = pt_pkg::ST_NEXT;
        else if (s <= 6'd1) st_next = pt_pkg::ST_DONE;
        else st_next = pt_pkg::ST_SQ;
      end
      pt_pkg::ST_SQ: st_next = pt_pkg::ST_SQ_WAIT;
      pt_pkg::ST_SQ_WAIT: if (!stat.busy) begin
        if (stat.x_nm1) st_next = pt_pkg::ST_NEXT;
        else if (j + 6'd1 >= s) st_next = pt_pkg::ST_DONE;
        else st_next = pt_pkg::ST_SQ;
      end
      pt_pkg::ST_NEXT: st_next = pt_pkg::ST_BASE;
      // hold the verdict until the output register can take it
      pt_pkg::ST_DONE: if (out_free) st_next = pt_pkg::ST_IDLE;
      default: st_next = pt_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    cmd.base = base_c;
    cmd.fermat = ferm;
    cmd.load = (st == pt_pkg::ST_IDLE) && start;
    cmd.split_step = (st == pt_pkg::ST_SPLIT) && stat.d_even;
    cmd.set_base = (st == pt_pkg::ST_POW);
    cmd.sq_start = (st == pt_pkg::ST_SQ);
    done = (st == pt_pkg::ST_DONE) && out_free;
    verdict = pass;
    idle = (st == pt_pkg::ST_IDLE);
  end
endmodule
`default_nettype wire

>>> hw/rtl/primality_tester.sv
// Items below 4, even items and items with a disabled method go from accept through the CHECK
// and DONE states to the output register; otherwise each modular multiply is bit-serial (one
// multiplier bit per cycle), and each exponent bit of a round takes up to one multiply and one squaring.
// One item at a time; the next is taken while a result waits in the output register, and a
// finished verdict holds in the controller until that register frees.
// Reset (rst, synchronous) sets test_method 1, round_count 5.
`default_nettype none
`include "primality_tester_assert.svh"
module primality_tester (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // candidate[62:0], zero pad
  input  wire logic        s_tlast,  // batch_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // is_prime, zero pad
  output logic             m_tlast,  // batch_end_out
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_data
);
  logic [2:0] method;
  logic [5:0] rounds;
  logic start, done, verdict, idle, last_q, res, out_free;
  pt_pkg::cmd_t cmd;
  pt_pkg::stat_t stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      method <= 3'd1; rounds <= 6'd5;
    end else if (cfg_we) begin
      if (cfg_index == pt_pkg::REG_METHOD) method <= cfg_data[2:0];
      else rounds <= cfg_data;
    end
  end

  assign s_tready = idle && !rst;
  assign start = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Output register, hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (start) last_q <= s_tlast;
      if (done) begin
        m_tvalid <= 1'b1; res <= verdict; m_tlast <= last_q;
      end else if (m_tready) m_tvalid <= 1'b0;
    end
  end
  assign m_tdata = {7'd0, res};

  pt_control u_ctl (.clk, .rst, .start, .method, .rounds_cfg(rounds), .out_free, .stat,
    .cmd, .done, .verdict, .idle);
  pt_datapath u_dp (.clk, .rst, .cand(s_tdata[62:0]), .cmd, .stat);

  `PT_ASSERT(a_load_idle, clk, rst, cmd.load |-> idle)
  `PT_ASSERT(a_done_once, clk, rst, done |=> !done)
endmodule
`default_nettype wire
